[rtl/core/tron_pkg.sv]
`default_nettype none
package tron_pkg;

   // Telnet command bytes
   localparam logic [7:0] BYTE_IAC  = 8'hFF;
   localparam logic [7:0] BYTE_DONT = 8'hFE;
   localparam logic [7:0] BYTE_DO   = 8'hFD;
   localparam logic [7:0] BYTE_WONT = 8'hFC;
   localparam logic [7:0] BYTE_WILL = 8'hFB;
   localparam logic [7:0] BYTE_SB   = 8'hFA;
   localparam logic [7:0] BYTE_SE   = 8'hF0;

   // Option codes
   localparam logic [7:0] OPTION_ECHO  = 8'd1;
   localparam logic [7:0] OPTION_SGA   = 8'd3;
   localparam logic [7:0] OPTION_TTYPE = 8'd24;
   localparam logic [7:0] OPTION_NAWS  = 8'd31;

   // Subnegotiation SEND / IS codes
   localparam logic [7:0] SUB_SEND = 8'd1;
   localparam logic [7:0] SUB_IS   = 8'd0;

   // Pending negotiation command
   localparam logic [1:0] CMD_WILL = 2'd0;
   localparam logic [1:0] CMD_WONT = 2'd1;
   localparam logic [1:0] CMD_DO   = 2'd2;
   localparam logic [1:0] CMD_DONT = 2'd3;

   // Configuration register indexes
   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   // Result destinations
   localparam logic DEST_USER  = 1'b0;
   localparam logic DEST_REPLY = 1'b1;

   // Receive parser states
   typedef enum logic [4:0] {
      MODE_DATA  = 5'b00001,
      MODE_IAC   = 5'b00010,
      MODE_CMD   = 5'b00100,
      MODE_SB    = 5'b01000,
      MODE_SBIAC = 5'b10000
   } parse_mode_type;

   // Work handed from the parser to the reply generator
   typedef enum logic [2:0] {
      JOB_DATA       = 3'd0,
      JOB_REPLY      = 3'd1,
      JOB_REPLY_NAWS = 3'd2,
      JOB_NAWS       = 3'd3,
      JOB_TTYPE      = 3'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_a;   // data byte, or reply command
      logic [7:0]   byte_b;   // reply option
   } job_type;

   // Index of the final byte of each job
   function automatic logic [3:0] job_last_index(input job_kind_type kind);
      logic [3:0] r;
      case (kind)
         JOB_DATA:       r = 4'd0;
         JOB_REPLY:      r = 4'd2;
         JOB_REPLY_NAWS: r = 4'd11;
         JOB_NAWS:       r = 4'd8;
         JOB_TTYPE:      r = 4'd10;
         default:        r = 4'd0;
      endcase
      return r;
   endfunction

   // Window size report: IAC SB NAWS cols rows IAC SE
   function automatic logic [7:0] naws_byte(input logic [3:0] idx,
                                            input logic [15:0] cols,
                                            input logic [15:0] rows);
      logic [7:0] r;
      case (idx)
         4'd0:    r = BYTE_IAC;
         4'd1:    r = BYTE_SB;
         4'd2:    r = OPTION_NAWS;
         4'd3:    r = cols[15:8];
         4'd4:    r = cols[7:0];
         4'd5:    r = rows[15:8];
         4'd6:    r = rows[7:0];
         4'd7:    r = BYTE_IAC;
         4'd8:    r = BYTE_SE;
         default: r = BYTE_SE;
      endcase
      return r;
   endfunction

   // Terminal type answer: IAC SB TTYPE IS "xterm" IAC SE
   function automatic logic [7:0] ttype_byte(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:    r = BYTE_IAC;
         4'd1:    r = BYTE_SB;
         4'd2:    r = OPTION_TTYPE;
         4'd3:    r = SUB_IS;
         4'd4:    r = 8'h78;
         4'd5:    r = 8'h74;
         4'd6:    r = 8'h65;
         4'd7:    r = 8'h72;
         4'd8:    r = 8'h6D;
         4'd9:    r = BYTE_IAC;
         4'd10:   r = BYTE_SE;
         default: r = BYTE_SE;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/tron_front.sv]
`default_nettype none
module tron_front
   import tron_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        operation,
   input  wire logic [7:0]  wire_byte,
   input  wire logic        sizes_nonzero,
   output logic             job_valid,
   output job_type          job
);

   parse_mode_type mode_ff, mode_in;
   logic [1:0] pending_ff, pending_in;
   logic [7:0] sub_opt_ff, sub_opt_in;
   logic       sub_seen_ff, sub_seen_in;
   logic [7:0] sub_first_ff, sub_first_in;
   logic       sub_has_ff, sub_has_in;
   logic       reports_ff, reports_in;

   // Parse one byte and decide what the back end must send
   always_comb begin
      mode_in      = mode_ff;
      pending_in   = pending_ff;
      sub_opt_in   = sub_opt_ff;
      sub_seen_in  = sub_seen_ff;
      sub_first_in = sub_first_ff;
      sub_has_in   = sub_has_ff;
      reports_in   = reports_ff;
      job_valid    = 1'b0;
      job.kind     = JOB_DATA;
      job.byte_a   = wire_byte;
      job.byte_b   = wire_byte;
      if (accept) begin
         if (operation) begin
            // window change: resend the size report while enabled
            job_valid = reports_ff;
            job.kind  = JOB_NAWS;
         end else begin
            case (mode_ff)
               MODE_IAC: begin
                  if (wire_byte == BYTE_IAC) begin
                     mode_in   = MODE_DATA;
                     job_valid = 1'b1;
                  end else if (wire_byte >= BYTE_WILL && wire_byte <= BYTE_DONT) begin
                     pending_in = 2'(wire_byte - BYTE_WILL);
                     mode_in    = MODE_CMD;
                  end else if (wire_byte == BYTE_SB) begin
                     sub_has_in   = 1'b0;
                     sub_first_in = 8'd0;
                     sub_seen_in  = 1'b0;
                     mode_in      = MODE_SB;
                  end else begin
                     mode_in = MODE_DATA;
                  end
               end
               MODE_CMD: begin
                  mode_in   = MODE_DATA;
                  job_valid = 1'b1;
                  job.kind  = JOB_REPLY;
                  case (pending_ff)
                     CMD_WILL: job.byte_a = (wire_byte == OPTION_ECHO || wire_byte == OPTION_SGA)
                                            ? BYTE_DO : BYTE_DONT;
                     CMD_WONT: job.byte_a = BYTE_DONT;
                     CMD_DO: begin
                        if (wire_byte == OPTION_SGA || wire_byte == OPTION_TTYPE) begin
                           job.byte_a = BYTE_WILL;
                        end else if (wire_byte == OPTION_NAWS) begin
                           job.byte_a = BYTE_WILL;
                           reports_in = 1'b1;
                           if (sizes_nonzero) begin
                              job.kind = JOB_REPLY_NAWS;
                           end
                        end else begin
                           job.byte_a = BYTE_WONT;
                        end
                     end
                     default: job.byte_a = BYTE_WONT;
                  endcase
               end
               MODE_SB: begin
                  if (!sub_seen_ff) begin
                     sub_opt_in  = wire_byte;
                     sub_seen_in = 1'b1;
                  end else if (wire_byte == BYTE_IAC) begin
                     mode_in = MODE_SBIAC;
                  end else if (!sub_has_ff) begin
                     sub_first_in = wire_byte;
                     sub_has_in   = 1'b1;
                  end
               end
               MODE_SBIAC: begin
                  if (wire_byte == BYTE_SE) begin
                     mode_in   = MODE_DATA;
                     job_valid = (sub_opt_ff == OPTION_TTYPE) && sub_has_ff &&
                                 (sub_first_ff == SUB_SEND);
                     job.kind  = JOB_TTYPE;
                  end else if (wire_byte == BYTE_IAC) begin
                     mode_in = MODE_SB;
                     if (!sub_has_ff) begin
                        sub_first_in = BYTE_IAC;
                        sub_has_in   = 1'b1;
                     end
                  end else begin
                     // malformed subnegotiation: drop it
                     mode_in = MODE_DATA;
                  end
               end
               default: begin
                  if (wire_byte == BYTE_IAC) begin
                     mode_in = MODE_IAC;
                  end else begin
                     mode_in   = MODE_DATA;
                     job_valid = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DATA;
         pending_ff   <= CMD_WILL;
         sub_opt_ff   <= 8'd0;
         sub_seen_ff  <= 1'b0;
         sub_first_ff <= 8'd0;
         sub_has_ff   <= 1'b0;
         reports_ff   <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         sub_opt_ff   <= sub_opt_in;
         sub_seen_ff  <= sub_seen_in;
         sub_first_ff <= sub_first_in;
         sub_has_ff   <= sub_has_in;
         reports_ff   <= reports_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/tron_queue.sv]
`default_nettype none
module tron_queue
   import tron_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output job_type      head_job
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   job_type slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == CntFull);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[rtl/core/tron_back.sv]
`default_nettype none
module tron_back
   import tron_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire job_type     head_job,
   input  wire logic        job_empty,
   output logic             job_pop,
   input  wire logic [15:0] window_columns,
   input  wire logic [15:0] window_rows,
   input  wire logic        out_pop,
   output logic             out_destination,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic [3:0] idx_ff, idx_in;
   logic       step;

   assign out_last        = (idx_ff == job_last_index(head_job.kind));
   assign out_destination = (head_job.kind == JOB_DATA) ? DEST_USER : DEST_REPLY;
   assign step            = out_pop && !job_empty;
   assign job_pop         = step && out_last;

   // Select the byte at the current position of the job
   always_comb begin
      case (head_job.kind)
         JOB_DATA: out_byte = head_job.byte_a;
         JOB_REPLY, JOB_REPLY_NAWS: begin
            case (idx_ff)
               4'd0:    out_byte = BYTE_IAC;
               4'd1:    out_byte = head_job.byte_a;
               4'd2:    out_byte = head_job.byte_b;
               default: out_byte = naws_byte(idx_ff - 4'd3, window_columns, window_rows);
            endcase
         end
         JOB_NAWS:  out_byte = naws_byte(idx_ff, window_columns, window_rows);
         JOB_TTYPE: out_byte = ttype_byte(idx_ff);
         default:   out_byte = head_job.byte_a;
      endcase
   end

   // Advance through the job, restart on its last byte
   always_comb begin
      idx_in = idx_ff;
      if (step) begin
         idx_in = out_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/telnet_receive_option_negotiator_unit.sv]
// Channel   Ports                                         Direction  Transfer
// req       req_push, req_full, req_operation,            in         push && !full
//           req_wire_byte
// rsp       rsp_empty, rsp_pop, rsp_destination,          out        pop && !empty
//           rsp_out_byte, rsp_last
// csr       csr_write_enable, csr_index, csr_write_data   in         write_enable
//
// The parser takes one byte per cycle whenever the job queue has room.
// Each job leaves as one result byte per cycle while rsp_pop is high: 1 for
// data, 3 for a reply, 9 to 12 for reports, so bursts of replies fill the
// queue and raise full. Each job is registered into the queue behind earlier jobs;
// rsp stalls never block the parser until the queue (QUEUE_DEPTH jobs) is full.
// Reset clears parser state, queue and sizes.
`default_nettype none
module telnet_receive_option_negotiator_unit
   import tron_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_wire_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_destination,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);

   logic [15:0] columns_ff, rows_ff;
   logic        accept;
   logic        job_valid;
   job_type     new_job;
   job_type     head_job;
   logic        job_pop;

   assign accept = req_push && !req_full;

   // Hold window size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 16'd0;
         rows_ff    <= 16'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLUMNS: columns_ff <= csr_write_data;
            CSR_ROWS:    rows_ff    <= csr_write_data;
            default:     columns_ff <= columns_ff;
         endcase
      end
   end

   tron_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (req_operation),
      .wire_byte     (req_wire_byte),
      .sizes_nonzero ((columns_ff != 16'd0) && (rows_ff != 16'd0)),
      .job_valid     (job_valid),
      .job           (new_job)
   );

   tron_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (new_job),
      .full     (req_full),
      .empty    (rsp_empty),
      .pop      (job_pop),
      .head_job (head_job)
   );

   tron_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .job_empty       (rsp_empty),
      .job_pop         (job_pop),
      .window_columns  (columns_ff),
      .window_rows     (rows_ff),
      .out_pop         (rsp_pop),
      .out_destination (rsp_destination),
      .out_byte        (rsp_out_byte),
      .out_last        (rsp_last)
   );

endmodule
`default_nettype wire
